[rtl/matrix_vector_multiply_fixed_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply unit
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_FIXED_UNIT_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_FIXED_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MVM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mvm_pkg.sv]
// ----------------------------------------------------------------------------
// mvm_pkg
// Types and constants shared by the matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 4096;
  localparam int ELEM_W    = 16;
  localparam int COL_W     = 8;
  localparam int ROW_W     = 12;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 9;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 40;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_MATRIX = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROWS_IN_USE = 1'b0;
  localparam logic CFG_COLS_IN_USE = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [COL_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [ACC_W-1:0] row_sum;
    logic                    last_row;
  } out_item_t;

  // matrix element leaving the memory read stage
  typedef struct packed {
    logic                     valid;
    logic                     row_done;
    logic [ROW_W-1:0]         row_index;
    logic                     last_row;
    logic signed [ELEM_W-1:0] elem_value;
  } mvm_stage_t;

endpackage

[rtl/mvm_accum.sv]
// ----------------------------------------------------------------------------
// mvm_accum
// Product register, row accumulator and output register with valid/stall.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_fixed_unit_assert.svh"

module mvm_accum
  import mvm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mvm_stage_t               stage,
  input  logic signed [ELEM_W-1:0] vec_value,
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_item
);

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_done;
  logic [ROW_W-1:0]         prod_row;
  logic                     prod_last;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic                     out_free;
  logic                     adv_prod;
  logic                     adv_stage;

  // handshake between stages
  assign out_free  = !out_valid || !out_stall;
  assign adv_prod  = prod_valid && (!prod_done || out_free);
  assign take      = !prod_valid || adv_prod;
  assign adv_stage = stage.valid && take;

  // running sum including the product in flight
  assign acc_next = acc + ACC_W'(prod);

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv_stage) begin
      prod_valid <= 1'b1;
    end else if (adv_prod) begin
      prod_valid <= 1'b0;
    end
    if (adv_stage) begin
      prod      <= stage.elem_value * vec_value;
      prod_done <= stage.row_done;
      prod_row  <= stage.row_index;
      prod_last <= stage.last_row;
    end
  end

  // accumulate, hand finished rows to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv_prod) begin
        acc <= prod_done ? '0 : acc_next;
      end
      if (adv_prod && prod_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (adv_prod && prod_done) begin
      out_item.row_index <= prod_row;
      out_item.row_sum   <= acc_next;
      out_item.last_row  <= prod_last;
    end
  end

  // accumulator restarts after every row
  `MVM_ASSERT_NEXT(a_acc_clear, adv_prod && prod_done, acc == '0, "row accumulator not cleared")
  // a result appears only from a finished row
  `MVM_ASSERT_SAME(a_out_src, $rose(out_valid), $past(adv_prod && prod_done),
                   "result without a finished row")
  // a finished row waits while the output is blocked
  `MVM_ASSERT_NEXT(a_row_hold, prod_valid && prod_done && out_valid && out_stall,
                   prod_valid && prod_done, "finished row lost while output stalled")

endmodule

[rtl/matrix_vector_multiply_fixed_unit.sv]
// ----------------------------------------------------------------------------
// matrix_vector_multiply_fixed_unit
// Streaming fixed-point y = A*x with a 256-entry vector memory.
// ----------------------------------------------------------------------------
// Load the vector first (req_type 0, one element per item at elem_index),
// then stream matrix elements in row-major order (req_type 1). Loads and
// matrix elements can follow each other back to back; a load is visible to
// a matrix element accepted in the next cycle. A row result passes the
// vector memory read, the 16x16 multiply and the accumulate into the output
// register after its last element is accepted. The input stalls only when
// a finished row meets a stalled output. Configuration writes take effect
// on the next matrix element.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_fixed_unit
  import mvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [ROWS_CFG_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  logic [ROWS_CFG_W-1:0]    rows_in_use;
  logic [COLS_CFG_W-1:0]    cols_in_use;
  logic [ROWS_CFG_W-1:0]    eff_rows;
  logic [COLS_CFG_W-1:0]    eff_cols;
  logic [COL_W-1:0]         col_cnt;
  logic [COL_W-1:0]         col_sel;
  logic [ROW_W-1:0]         row_cnt;
  logic                     row_done;
  logic                     last_row;
  logic                     accept;
  logic                     load_accept;
  logic                     mat_accept;
  logic                     take;
  logic signed [ELEM_W-1:0] vec_mem [MAX_COLS];
  logic signed [ELEM_W-1:0] vec_rdata;
  mvm_stage_t               stage;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_CFG_W'(1);
      cols_in_use <= COLS_CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        CFG_COLS_IN_USE: cols_in_use <= cfg_data[COLS_CFG_W-1:0];
        default:         ;
      endcase
    end
  end

  // clamp register values to the supported range
  always_comb begin
    if (cols_in_use == '0) begin
      eff_cols = COLS_CFG_W'(1);
    end else if (cols_in_use > COLS_CFG_W'(MAX_COLS)) begin
      eff_cols = COLS_CFG_W'(MAX_COLS);
    end else begin
      eff_cols = cols_in_use;
    end
    if (rows_in_use == '0) begin
      eff_rows = ROWS_CFG_W'(1);
    end else if (rows_in_use > ROWS_CFG_W'(MAX_ROWS)) begin
      eff_rows = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_in_use;
    end
  end

  // column select and row end
  always_comb begin
    if ({1'b0, col_cnt} >= eff_cols) begin
      col_sel = COL_W'(eff_cols - COLS_CFG_W'(1));
    end else begin
      col_sel = col_cnt;
    end
    row_done = ({1'b0, col_sel} + COLS_CFG_W'(1)) >= eff_cols;
    last_row = ({1'b0, row_cnt} + ROWS_CFG_W'(1)) >= eff_rows;
  end

  // input handshake
  assign in_stall    = stage.valid && !take;
  assign accept      = in_valid && !in_stall;
  assign load_accept = accept && (in_item.req_type == REQ_LOAD)
                       && (int'(in_item.elem_index) < MAX_COLS);
  assign mat_accept  = accept && (in_item.req_type == REQ_MATRIX);

  // vector memory: write on load, read on matrix element
  always_ff @(posedge clk) begin
    if (load_accept) begin
      vec_mem[in_item.elem_index] <= in_item.elem_value;
    end
    if (mat_accept) begin
      vec_rdata <= vec_mem[col_sel];
    end
  end

  // column and row counters, read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt     <= '0;
      row_cnt     <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (mat_accept) begin
        stage.valid <= 1'b1;
        if (row_done) begin
          col_cnt <= '0;
          row_cnt <= last_row ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_sel + COL_W'(1);
        end
      end else if (take) begin
        stage.valid <= 1'b0;
      end
    end
    if (mat_accept) begin
      stage.row_done   <= row_done;
      stage.row_index  <= row_cnt;
      stage.last_row   <= last_row;
      stage.elem_value <= in_item.elem_value;
    end
  end

  mvm_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .vec_value (vec_rdata),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming fixed-point matrix-vector multiply.
// ----------------------------------------------------------------------------
// A cycle-free software copy of the datapath (vector store, row accumulator,
// column and row counters, register clamping) predicts every row result at
// the moment each item is accepted. A monitor compares each accepted row
// result with the oldest prediction. Named tests cover the reset defaults,
// extreme element values, register changes in the middle of a row, clamping
// of zero and oversized register values with full-length rows, and a long
// random stream. Both handshakes idle at random, with stretches of full
// throughput.
// ----------------------------------------------------------------------------
module tb_top;
  import mvm_pkg::*;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no item moving
  localparam int SETTLE_CYCLES = 8;     // covers the 3-stage pipeline
  localparam int RANDOM_ITEMS  = 250;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = CFG_ROWS_IN_USE;
  logic [ROWS_CFG_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;

  // predictor state
  logic signed [ELEM_W-1:0] vec_copy [MAX_COLS];
  logic [MAX_COLS-1:0]      vec_written;
  logic signed [ACC_W-1:0]  row_acc;
  int unsigned              col_pos;
  int unsigned              row_pos;
  logic [ROWS_CFG_W-1:0]    rows_reg;
  logic [COLS_CFG_W-1:0]    cols_reg;
  out_item_t                rows_due [$];

  // run statistics
  int errors;
  int n_sent;
  int n_loads;
  int n_rows;
  int n_cfg;

  bit no_gaps;      // full-throughput stretch on both sides
  bit in_fire;
  bit out_fire;
  int idle_cycles;
  int stall_left;
  int free_left;

  matrix_vector_multiply_fixed_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int unsigned active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  task automatic accumulate_item(in_item_t it);
    int unsigned             ncols;
    int unsigned             col;
    logic signed [ACC_W-1:0] prod;
    out_item_t               res;
    bit                      last;
    if (it.req_type == REQ_LOAD) begin
      vec_copy[it.elem_index]    = it.elem_value;
      vec_written[it.elem_index] = 1'b1;
      n_loads++;
      return;
    end
    ncols = active_cols();
    col   = (col_pos >= ncols) ? ncols - 1 : col_pos;
    prod  = $signed(it.elem_value) * vec_copy[col];
    row_acc = row_acc + prod;
    if (col + 1 < ncols) begin
      col_pos = col + 1;
      return;
    end
    // row complete
    last          = (row_pos + 1 >= active_rows());
    res.row_index = ROW_W'(row_pos);
    res.row_sum   = row_acc;
    res.last_row  = last;
    rows_due.push_back(res);
    row_acc = '0;
    col_pos = 0;
    row_pos = last ? 0 : row_pos + 1;
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(ELEM_W-1){1'b0}}};
      1: return {1'b0, {(ELEM_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic int rand_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic in_item_t make_item(logic kind, logic [COL_W-1:0] idx,
                                         logic [ELEM_W-1:0] val);
    in_item_t it;
    it.req_type   = kind;
    it.elem_index = idx;
    it.elem_value = val;
    return it;
  endfunction

  function automatic in_item_t matrix_elem(logic [ELEM_W-1:0] val);
    return make_item(REQ_MATRIX, COL_W'($urandom), val);
  endfunction

  // sends one item; valid stays high so back-to-back items need no toggle
  task automatic send_item(in_item_t it);
    int gap;
    bit taken;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    accumulate_item(it);
    n_sent++;
  endtask

  // idle the input, then wait until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
  endtask

  // register write, only with the datapath empty
  task automatic write_reg(logic idx, logic [ROWS_CFG_W-1:0] val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS_IN_USE) rows_reg = val;
    else cols_reg = val[COLS_CFG_W-1:0];
    n_cfg++;
  endtask

  // every column that can be read must hold a written value
  task automatic fill_vector();
    for (int i = 0; i < active_cols(); i++) begin
      if (!vec_written[i]) send_item(make_item(REQ_LOAD, COL_W'(i), rand_elem()));
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall, monitor, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || no_gaps) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      free_left  = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                              : $urandom_range(0, 8);
      case ($urandom_range(0, 19))
        0:       stall_left = $urandom_range(20, 60);
        1, 2, 3: stall_left = $urandom_range(4, 12);
        default: stall_left = $urandom_range(1, 3);
      endcase
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_row(out_item_t got);
    out_item_t want;
    if (rows_due.size() == 0) begin
      report_mismatch($sformatf("row %0d result with none expected", got.row_index));
    end else begin
      want = rows_due.pop_front();
      n_rows++;
      if (got.row_index !== want.row_index)
        report_mismatch($sformatf("row_index got %0d expected %0d",
                                  got.row_index, want.row_index));
      if (got.row_sum !== want.row_sum)
        report_mismatch($sformatf("row %0d row_sum got %0d expected %0d",
                                  want.row_index, $signed(got.row_sum),
                                  $signed(want.row_sum)));
      if (got.last_row !== want.last_row)
        report_mismatch($sformatf("row %0d last_row got %b expected %b",
                                  want.row_index, got.last_row, want.last_row));
    end
  endtask

  // sample between edges, all drives change at the rising edge
  always @(negedge clk) begin
    in_fire  = !rst && in_valid && !in_stall;
    out_fire = !rst && out_valid && !out_stall;
    if (out_fire) check_row(out_item);
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d rows outstanding",
                 idle_cycles, rows_due.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // registers at reset: one row of one column, every element ends a row
  task automatic test_reset_defaults();
    send_item(make_item(REQ_LOAD, 8'd0, 16'h8000));
    send_item(make_item(REQ_LOAD, 8'd255, 16'h7fff));
    send_item(matrix_elem(16'h8000));
    send_item(matrix_elem(16'h7fff));
    send_item(matrix_elem(16'h0001));
    send_item(matrix_elem(16'h0000));
  endtask

  // extreme products, a load between two columns, back-to-back items
  task automatic test_extreme_values();
    write_reg(CFG_COLS_IN_USE, 13'd4);
    write_reg(CFG_ROWS_IN_USE, 13'd3);
    no_gaps = 1'b1;
    send_item(make_item(REQ_LOAD, 8'd0, 16'h8000));
    send_item(make_item(REQ_LOAD, 8'd1, 16'h7fff));
    send_item(make_item(REQ_LOAD, 8'd2, 16'h0001));
    send_item(make_item(REQ_LOAD, 8'd3, 16'hffff));
    repeat (4) send_item(matrix_elem(16'h8000));
    repeat (4) send_item(matrix_elem(16'h7fff));
    // sender holds off until the block has emptied
    drain_results();
    send_item(matrix_elem(16'h0000));
    send_item(matrix_elem(16'h8000));
    send_item(make_item(REQ_LOAD, 8'd2, 16'h8000));
    send_item(matrix_elem(16'h8000));
    send_item(matrix_elem(16'h7fff));
    no_gaps = 1'b0;
  endtask

  // column and row counts changed part way through a row and a matrix
  task automatic test_midrow_reconfig();
    write_reg(CFG_COLS_IN_USE, 13'd8);
    write_reg(CFG_ROWS_IN_USE, 13'd4);
    fill_vector();
    repeat (5) send_item(matrix_elem(rand_elem()));
    // column counter now beyond the new count: next element closes the row
    write_reg(CFG_COLS_IN_USE, 13'd3);
    send_item(matrix_elem(rand_elem()));
    repeat (3) send_item(matrix_elem(rand_elem()));
    // row counter beyond the new row count: flagged last and wraps
    write_reg(CFG_ROWS_IN_USE, 13'd1);
    repeat (3) send_item(matrix_elem(rand_elem()));
    send_item(matrix_elem(rand_elem()));
    write_reg(CFG_COLS_IN_USE, 13'd6);
    repeat (5) send_item(matrix_elem(rand_elem()));
  endtask

  // zero and oversized register values, full row length
  task automatic test_register_clamp();
    write_reg(CFG_COLS_IN_USE, 13'd0);
    write_reg(CFG_ROWS_IN_USE, 13'd0);
    repeat (3) send_item(matrix_elem(rand_elem()));
    // 8191 acts as 4096 rows: no early last-row flag
    write_reg(CFG_ROWS_IN_USE, 13'h1fff);
    no_gaps = 1'b1;
    repeat (16) send_item(matrix_elem(rand_elem()));
    no_gaps = 1'b0;
    // 511 columns act as 256
    write_reg(CFG_COLS_IN_USE, 13'h1ff);
    write_reg(CFG_ROWS_IN_USE, 13'd2);
    fill_vector();
    repeat (MAX_COLS) send_item(matrix_elem(rand_elem()));
    write_reg(CFG_COLS_IN_USE, 13'd256);
    write_reg(CFG_ROWS_IN_USE, 13'd4096);
    repeat (MAX_COLS) send_item(matrix_elem(rand_elem()));
  endtask

  // phases of random register settings and random streams
  task automatic test_random_stream();
    int sent;
    int len;
    int r;
    logic [ROWS_CFG_W-1:0] rows_val;
    logic [ROWS_CFG_W-1:0] cols_val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       cols_val = 13'd0;
        1:       cols_val = 13'd256;
        2:       cols_val = 13'h1ff;
        3:       cols_val = 13'd300;
        default: cols_val = ROWS_CFG_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 15))
        0:       rows_val = 13'd0;
        1:       rows_val = 13'd4096;
        2:       rows_val = 13'h1fff;
        3:       rows_val = ROWS_CFG_W'($urandom_range(9, 8191));
        default: rows_val = ROWS_CFG_W'($urandom_range(1, 8));
      endcase
      // pick the write order at random so both kinds of mid-row change happen
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_COLS_IN_USE, cols_val);
        write_reg(CFG_ROWS_IN_USE, rows_val);
      end else begin
        write_reg(CFG_ROWS_IN_USE, rows_val);
        write_reg(CFG_COLS_IN_USE, cols_val);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      fill_vector();
      len = $urandom_range(20, 100);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) drain_results();
        if (r < 12) send_item(make_item(REQ_LOAD, COL_W'($urandom), rand_elem()));
        else send_item(matrix_elem(rand_elem()));
        sent++;
      end
      no_gaps = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    vec_written = '0;
    row_acc     = '0;
    col_pos     = 0;
    row_pos     = 0;
    rows_reg    = ROWS_CFG_W'(1);
    cols_reg    = COLS_CFG_W'(1);
    no_gaps     = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extreme_values();
    test_midrow_reconfig();
    test_register_clamp();
    test_random_stream();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run: %0d items (%0d vector loads), %0d row results checked, %0d register writes",
             n_sent, n_loads, n_rows, n_cfg);
    $display("run: %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
